[design/rgb_3x3_kernel_filter_assert.svh]
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter_assert.svh
// Assertion macros shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_KERNEL_FILTER_ASSERT_SVH
`define RGB_3X3_KERNEL_FILTER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define RKF_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication
`define RKF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/rkf_pkg.sv]
// ----------------------------------------------------------------------------
// rkf_pkg
// Types and constants of the RGB 3x3 kernel filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rkf_pkg;

   // Pixel channel width
   localparam int CHAN_W = 8;

   // Kernel geometry (fixed 3x3)
   localparam int KERNEL_DIM = 3;

   // Signed kernel sum width per channel (covers -2040..4080)
   localparam int SUM_W = 14;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'd1;

   // Filter modes
   typedef logic [1:0] mode_type;

   localparam mode_type MODE_EDGE    = 2'd0;
   localparam mode_type MODE_SHARPEN = 2'd1;
   localparam mode_type MODE_BOX     = 2'd2;
   localparam mode_type MODE_GAUSS   = 2'd3;

   // Packed RGB pixel
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

endpackage

[design/rkf_req_if.sv]
// ----------------------------------------------------------------------------
// rkf_req_if
// Input channel of the filter: one pixel or flush item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rkf_req_if import rkf_pkg::*; ();

   logic              valid;
   logic              ready;
   logic              op;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, op, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, op, red_in, green_in, blue_in, output ready);

endinterface

[design/rkf_rsp_if.sv]
// ----------------------------------------------------------------------------
// rkf_rsp_if
// Result channel of the filter: one filtered pixel per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rkf_rsp_if import rkf_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              last_of_run;
   logic              frame_done;

   modport source (output valid, red_out, green_out, blue_out, last_of_run, frame_done,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, last_of_run, frame_done,
                   output ready);

endinterface

[design/rgb_3x3_kernel_filter.sv]
// Pipeline: an accepted item passes the stage 1 registers, the window register, the
//   kernel sums and the output register before its result is on rsp, and the two
//   extra results at a row's end follow it. Throughput: one item per cycle unless rsp
//   stalls; a result row's last item holds the window stage until its three results leave.
// Reset: clears the pipeline valids, counters, flush phase and registers
//   (filter mode edge detect, width 640); the line memories are not cleared.
`timescale 1ns / 1ps

`include "rgb_3x3_kernel_filter_assert.svh"

// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter
// Streaming 3x3 convolution on RGB pixels with two line memories and a
// window register, selectable edge / sharpen / box / Gaussian kernel.
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_filter import rkf_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   rkf_req_if.sink               req,
   rkf_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int RESET_WLAST = (640 > MAX_WIDTH) ? MAX_WIDTH - 1 : 639;

   // Flush phase codes
   localparam logic [1:0] PH_NONE   = 2'd0;
   localparam logic [1:0] PH_PAD    = 2'd1;
   localparam logic [1:0] PH_FIRST  = 2'd2;
   localparam logic [1:0] PH_SECOND = 2'd3;

   // Row counter saturates here: rows from the third on produce results
   localparam logic [1:0] ROW_ACTIVE = 2'd2;

   // Result index within one item's run
   localparam logic [1:0] RES_MAIN  = 2'd0;
   localparam logic [1:0] RES_TAIL2 = 2'd2;

   // Floor division by 9 through a 16-bit reciprocal
   localparam logic [SUM_W-2:0] RECIP9      = 13'd7282;
   localparam int               RECIP_SHIFT = 16;
   localparam logic [SUM_W-2:0] CHAN_MAX    = 13'd255;

   // Kernel sum of one channel over a 3x3 tap set (row-major)
   function automatic logic signed [SUM_W-1:0] kernel_sum(
      input mode_type                                mode,
      input logic [KERNEL_DIM*KERNEL_DIM-1:0][CHAN_W-1:0] t
   );
      logic [SUM_W-1:0] c;
      logic [SUM_W-1:0] e;
      logic [SUM_W-1:0] q;
      logic [SUM_W-1:0] s;
      c = SUM_W'(t[4]);
      e = SUM_W'(t[1]) + SUM_W'(t[3]) + SUM_W'(t[5]) + SUM_W'(t[7]);
      q = SUM_W'(t[0]) + SUM_W'(t[2]) + SUM_W'(t[6]) + SUM_W'(t[8]);
      case (mode)
         MODE_EDGE:    s = (c << 3) - e - q;
         MODE_SHARPEN: s = (c << 2) + c - e;
         MODE_BOX:     s = c + e + q;
         default:      s = (c << 2) + (e << 1) + q;
      endcase
      return signed'(s);
   endfunction

   // Clamp negative to zero, apply divisor, saturate to channel range
   function automatic logic [CHAN_W-1:0] finish(
      input mode_type                mode,
      input logic signed [SUM_W-1:0] sum
   );
      logic [SUM_W-2:0]         mag;
      logic [2*(SUM_W-1)-1:0]   prod;
      logic [SUM_W-2:0]         quo;
      mag  = sum[SUM_W-1] ? '0 : sum[SUM_W-2:0];
      prod = mag * RECIP9;
      case (mode)
         MODE_BOX:   quo = (SUM_W-1)'(prod >> RECIP_SHIFT);
         MODE_GAUSS: quo = mag >> 4;
         default:    quo = mag;
      endcase
      return (quo > CHAN_MAX) ? {CHAN_W{1'b1}} : quo[CHAN_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   mode_type         mode_ff;
   logic [COL_W-1:0] wlast_ff;
   logic [COL_W-1:0] wlast_in;
   logic             width_wr;

   assign width_wr = csr_we && (csr_index == CSR_IMAGE_WIDTH);

   // Last column index from the written width, with the width clamped to 3..MAX_WIDTH
   always_comb begin
      if (csr_wdata < CSR_DATA_W'(3)) begin
         wlast_in = COL_W'(2);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         wlast_in = COL_W'(MAX_WIDTH - 1);
      end else begin
         wlast_in = COL_W'(csr_wdata - CSR_DATA_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_EDGE;
         wlast_ff <= COL_W'(RESET_WLAST);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FILTER_MODE: mode_ff  <= csr_wdata[1:0];
            CSR_IMAGE_WIDTH: wlast_ff <= wlast_in;
            default:         ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake and stall control
   // ------------------------------------------------------------------
   logic       accept;
   logic       adv;
   logic       emit;
   logic       s2_pend;
   logic       s2_last;
   logic       s2_free;
   logic       s1_v_ff;
   logic       s2_v_ff;
   logic       s2_main_ff;
   logic       s2_tail_ff;
   logic       s2_fe_ff;
   logic [1:0] s2_k_ff;
   logic       s3_v_ff;
   logic       rsp_v_ff;

   assign adv     = !rsp_v_ff || rsp.ready;
   assign s2_pend = s2_v_ff && s2_main_ff;
   assign s2_last = s2_tail_ff ? (s2_k_ff == RES_TAIL2) : 1'b1;
   assign emit    = s2_pend && adv;
   assign s2_free = !s2_pend || (adv && s2_last);

   assign req.ready = !s1_v_ff || s2_free;
   assign accept    = req.valid && req.ready;

   // ------------------------------------------------------------------
   // Stage 0: position tracking and flush handling
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [1:0]       row_cnt_ff;
   logic [1:0]       row_cnt_in;
   logic [1:0]       phase_ff;
   logic [1:0]       phase_in;
   logic [1:0]       phase_eff;
   pix_type          pix_in;
   logic             row_end;
   logic             active;
   logic             main_in;
   logic             tail_in;
   logic             fe_in;

   always_comb begin
      phase_eff = phase_ff;
      if (req.op && (phase_ff == PH_NONE)) begin
         phase_eff = (col_ff == '0) ? PH_FIRST : PH_PAD;
      end

      pix_in = '0;
      if (phase_eff == PH_NONE) begin
         pix_in = '{red: req.red_in, green: req.green_in, blue: req.blue_in};
      end

      row_end = (col_ff == wlast_ff);
      active  = (row_cnt_ff == ROW_ACTIVE);
      main_in = active && (col_ff >= COL_W'(2));
      tail_in = active && row_end;
      fe_in   = row_end && (phase_eff == PH_SECOND);

      col_in     = col_ff + COL_W'(1);
      row_cnt_in = row_cnt_ff;
      phase_in   = phase_eff;
      if (row_end) begin
         col_in     = '0;
         row_cnt_in = active ? row_cnt_ff : row_cnt_ff + 2'd1;
         if (phase_eff == PH_SECOND) begin
            row_cnt_in = '0;
            phase_in   = PH_NONE;
         end else if (phase_eff != PH_NONE) begin
            phase_in = phase_eff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || width_wr) begin
         col_ff     <= '0;
         row_cnt_ff <= '0;
         phase_ff   <= PH_NONE;
      end else if (accept) begin
         col_ff     <= col_in;
         row_cnt_ff <= row_cnt_in;
         phase_ff   <= phase_in;
      end
   end

   // ------------------------------------------------------------------
   // Line memories: top holds row R-2, mid holds row R-1
   // ------------------------------------------------------------------
   pix_type          top_mem [MAX_WIDTH];
   pix_type          mid_mem [MAX_WIDTH];
   pix_type          top_rd_ff;
   pix_type          mid_rd_ff;
   pix_type          s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_main_ff;
   logic             s1_tail_ff;
   logic             s1_fe_ff;

   // Read both lines at the item's column; mid takes the new pixel now,
   // top takes the old mid in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff       <= top_mem[col_ff];
         mid_rd_ff       <= mid_mem[col_ff];
         mid_mem[col_ff] <= pix_in;
      end
      if (s1_v_ff) begin
         top_mem[s1_col_ff] <= mid_rd_ff;
      end
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff <= 1'b1;
      end else if (s2_free) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix_in;
         s1_col_ff  <= col_ff;
         s1_main_ff <= main_in;
         s1_tail_ff <= tail_in;
         s1_fe_ff   <= fe_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: window register and result sequencing
   // ------------------------------------------------------------------
   pix_type win_ff [KERNEL_DIM][KERNEL_DIM];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_v_ff) begin
         for (int i = 0; i < KERNEL_DIM; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= top_rd_ff;
         win_ff[1][2] <= mid_rd_ff;
         win_ff[2][2] <= s1_pix_ff;
         s2_main_ff   <= s1_main_ff;
         s2_tail_ff   <= s1_tail_ff;
         s2_fe_ff     <= s1_fe_ff;
         s2_k_ff      <= RES_MAIN;
      end else if (emit && !s2_last) begin
         s2_k_ff <= s2_k_ff + 2'd1;
      end
   end

   // Tap selection: row-end results shift in one or two zero columns
   pix_type taps [KERNEL_DIM][KERNEL_DIM];

   always_comb begin
      for (int i = 0; i < KERNEL_DIM; i++) begin
         case (s2_k_ff)
            RES_MAIN: begin
               taps[i][0] = win_ff[i][0];
               taps[i][1] = win_ff[i][1];
               taps[i][2] = win_ff[i][2];
            end
            RES_TAIL2: begin
               taps[i][0] = win_ff[i][2];
               taps[i][1] = '0;
               taps[i][2] = '0;
            end
            default: begin
               taps[i][0] = win_ff[i][1];
               taps[i][1] = win_ff[i][2];
               taps[i][2] = '0;
            end
         endcase
      end
   end

   // Per-channel tap vectors
   logic [KERNEL_DIM*KERNEL_DIM-1:0][CHAN_W-1:0] red_taps;
   logic [KERNEL_DIM*KERNEL_DIM-1:0][CHAN_W-1:0] green_taps;
   logic [KERNEL_DIM*KERNEL_DIM-1:0][CHAN_W-1:0] blue_taps;

   always_comb begin
      for (int i = 0; i < KERNEL_DIM; i++) begin
         for (int j = 0; j < KERNEL_DIM; j++) begin
            red_taps[i*KERNEL_DIM+j]   = taps[i][j].red;
            green_taps[i*KERNEL_DIM+j] = taps[i][j].green;
            blue_taps[i*KERNEL_DIM+j]  = taps[i][j].blue;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: kernel sums
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0] red_sum_ff;
   logic signed [SUM_W-1:0] green_sum_ff;
   logic signed [SUM_W-1:0] blue_sum_ff;
   mode_type                s3_mode_ff;
   logic                    s3_last_ff;
   logic                    s3_fd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         red_sum_ff   <= kernel_sum(mode_ff, red_taps);
         green_sum_ff <= kernel_sum(mode_ff, green_taps);
         blue_sum_ff  <= kernel_sum(mode_ff, blue_taps);
         s3_mode_ff   <= mode_ff;
         s3_last_ff   <= s2_last;
         s3_fd_ff     <= s2_last && s2_fe_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: divide, saturate, output register
   // ------------------------------------------------------------------
   logic [CHAN_W-1:0] red_out_ff;
   logic [CHAN_W-1:0] green_out_ff;
   logic [CHAN_W-1:0] blue_out_ff;
   logic              last_ff;
   logic              fd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_v_ff) begin
         red_out_ff   <= finish(s3_mode_ff, red_sum_ff);
         green_out_ff <= finish(s3_mode_ff, green_sum_ff);
         blue_out_ff  <= finish(s3_mode_ff, blue_sum_ff);
         last_ff      <= s3_last_ff;
         fd_ff        <= s3_fd_ff;
      end
   end

   assign rsp.valid       = rsp_v_ff;
   assign rsp.red_out     = red_out_ff;
   assign rsp.green_out   = green_out_ff;
   assign rsp.blue_out    = blue_out_ff;
   assign rsp.last_of_run = last_ff;
   assign rsp.frame_done  = fd_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `RKF_ASSERT_ALWAYS(a_col_in_row, clock, reset, col_ff <= wlast_ff,
      "column counter beyond row width")
   `RKF_ASSERT_IMPLY(a_tail_index, clock, reset, s2_v_ff && (s2_k_ff != RES_MAIN),
      s2_tail_ff, "tail result index on an item without row-end results")
   `RKF_ASSERT_NEXT(a_window_hold, clock, reset, s2_pend && !adv,
      s2_pend && $stable(s2_k_ff), "window stage moved while output stalled")
   `RKF_ASSERT_IMPLY(a_frame_done_last, clock, reset, rsp.valid && rsp.frame_done,
      rsp.last_of_run, "frame end flagged on a result that is not last of its run")

endmodule

[bench/rkf_tb_pkg.sv]
// ----------------------------------------------------------------------------
// rkf_tb_pkg
// Item codes shared by the filter bench's stimulus and scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rkf_tb_pkg;

   // op field of a request item
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

endpackage

[bench/rkf_filter_checker.sv]
// ----------------------------------------------------------------------------
// rkf_filter_checker
// Watches the filter's request, result and register ports, keeps its own
// copy of the line buffers, window and frame counters, predicts every
// filtered pixel and compares each accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rkf_filter_checker import rkf_pkg::*, rkf_tb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rkf_req_if                    req,
   rkf_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int unsigned LINE_DEPTH = 2048;
   localparam int unsigned ROW_CAP    = 65535;

   typedef pix_type pix_window_type [0:2][0:2];

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_of_run;
      logic              frame_done;
   } filtered_pixel_type;

   typedef enum int {FLUSH_NONE, FLUSH_PAD, FLUSH_FIRST, FLUSH_SECOND} flush_phase_type;

   // Shadow state of the filter
   pix_type                 older_row [0:LINE_DEPTH-1];
   pix_type                 newer_row [0:LINE_DEPTH-1];
   pix_window_type          taps;
   int unsigned             row_count;
   int unsigned             col_count;
   flush_phase_type         phase;
   mode_type                filter_mode;
   logic [CSR_DATA_W-1:0]   width_reg;
   filtered_pixel_type      expected_pixels [$];

   initial fail_count = 0;

   // Kernel weight of tap (i,j) for a mode
   function automatic int tap_weight(mode_type m, int i, int j);
      case (m)
         MODE_EDGE:    return (i == 1 && j == 1) ? 8 : -1;
         MODE_SHARPEN: begin
            if (i == 1 && j == 1) return 5;
            if (i == 1 || j == 1) return -1;
            return 0;
         end
         MODE_BOX:     return 1;
         default:      return (i == 1 ? 2 : 1) * (j == 1 ? 2 : 1);
      endcase
   endfunction

   // One colour channel: weighted sum, clamp at zero, divide, saturate
   function automatic logic [CHAN_W-1:0] convolve_channel(pix_window_type win, mode_type m,
                                                          int chan);
      int acc;
      int v;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            case (chan)
               0:       v = win[i][j].red;
               1:       v = win[i][j].green;
               default: v = win[i][j].blue;
            endcase
            acc += tap_weight(m, i, j) * v;
         end
      end
      if (acc < 0) acc = 0;
      if (m == MODE_BOX) acc = acc / 9;
      else if (m == MODE_GAUSS) acc = acc / 16;
      if (acc > 255) acc = 255;
      return acc[CHAN_W-1:0];
   endfunction

   function automatic filtered_pixel_type filter_window(pix_window_type win, mode_type m);
      filtered_pixel_type res;
      res.red         = convolve_channel(win, m, 0);
      res.green       = convolve_channel(win, m, 1);
      res.blue        = convolve_channel(win, m, 2);
      res.last_of_run = 1'b0;
      res.frame_done  = 1'b0;
      return res;
   endfunction

   // Shift the window one column left, new column enters on the right
   function automatic pix_window_type shift_window(pix_window_type win, pix_type top,
                                                   pix_type mid, pix_type bot);
      pix_window_type res;
      for (int i = 0; i < 3; i++) begin
         res[i][0] = win[i][1];
         res[i][1] = win[i][2];
      end
      res[0][2] = top;
      res[1][2] = mid;
      res[2][2] = bot;
      return res;
   endfunction

   function automatic void restart_frame();
      row_count = 0;
      col_count = 0;
      phase     = FLUSH_NONE;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            taps[i][j] = '0;
   endfunction

   // Advance the shadow state by one accepted item and queue its results
   function automatic void predict_item(logic op, pix_type pix_in);
      int unsigned        w;
      int unsigned        col;
      pix_type            pix;
      pix_type            top;
      pix_type            mid;
      logic               active;
      logic               row_end;
      logic               frame_end;
      pix_window_type     tail;
      filtered_pixel_type res [0:2];
      int                 n;

      w = width_reg < 3 ? 3 : (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
      n = 0;
      frame_end = 1'b0;

      // first flush item starts padding, or goes straight to the flush rows
      if (op == OP_FLUSH && phase == FLUSH_NONE)
         phase = (col_count == 0) ? FLUSH_FIRST : FLUSH_PAD;
      pix = (phase == FLUSH_NONE) ? pix_in : '0;

      col = (col_count >= w) ? w - 1 : col_count;
      top = older_row[col];
      mid = newer_row[col];
      older_row[col] = mid;
      newer_row[col] = pix;
      taps = shift_window(taps, top, mid, pix);

      active  = row_count >= 2;
      row_end = (col == w - 1);

      if (active && col >= 2) begin
         res[n] = filter_window(taps, filter_mode);
         n++;
      end
      // last two columns of the result row, right taps outside the image
      if (active && row_end) begin
         tail = shift_window(taps, '0, '0, '0);
         res[n] = filter_window(tail, filter_mode);
         n++;
         tail = shift_window(tail, '0, '0, '0);
         res[n] = filter_window(tail, filter_mode);
         n++;
      end

      if (row_end) begin
         col_count = 0;
         if (row_count < ROW_CAP) row_count++;
         if (phase == FLUSH_SECOND) frame_end = 1'b1;
         else if (phase != FLUSH_NONE) phase = flush_phase_type'(phase + 1);
      end else begin
         col_count = col + 1;
      end

      if (n > 0) begin
         res[n-1].last_of_run = 1'b1;
         res[n-1].frame_done  = frame_end;
      end
      for (int k = 0; k < n; k++)
         expected_pixels.push_back(res[k]);
      if (frame_end) restart_frame();
   endfunction

   function automatic void compare_field(string name, logic [CHAN_W-1:0] want,
                                         logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type want;
      if (reset) begin
         for (int k = 0; k < LINE_DEPTH; k++) begin
            older_row[k] = '0;
            newer_row[k] = '0;
         end
         restart_frame();
         filter_mode = MODE_EDGE;
         width_reg   = 12'd640;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_FILTER_MODE: filter_mode = csr_wdata[1:0];
               CSR_IMAGE_WIDTH: begin
                  width_reg = csr_wdata;
                  restart_frame();
               end
               default: ;
            endcase
         end

         // results leave in order, oldest expectation first
         if (rsp.valid && rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result item with no expected pixel pending");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("red_out", want.red, rsp.red_out);
               compare_field("green_out", want.green, rsp.green_out);
               compare_field("blue_out", want.blue, rsp.blue_out);
               compare_field("last_of_run", CHAN_W'(want.last_of_run),
                             CHAN_W'(rsp.last_of_run));
               compare_field("frame_done", CHAN_W'(want.frame_done),
                             CHAN_W'(rsp.frame_done));
            end
         end

         if (req.valid && req.ready)
            predict_item(req.op, {req.red_in, req.green_in, req.blue_in});
      end
      pending <= expected_pixels.size();
   end

endmodule

[bench/rgb_3x3_kernel_filter_tb.sv]
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter_tb
// Drives frames of RGB pixels and flush items through the 3x3 filter under
// all four kernels and a range of widths, with random gaps on both channels;
// the scoreboard module predicts and checks every filtered pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_3x3_kernel_filter_tb;
   import rkf_pkg::*;
   import rkf_tb_pkg::*;

   localparam int LONG_HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES    = 12;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_results;

   // idling switches for both channels and long-hold requests for the result side
   bit                    sender_gaps;
   bit                    receiver_gaps;
   int                    holds_requested = 0;
   int                    holds_done = 0;

   rkf_req_if req_ch ();
   rkf_rsp_if rsp_ch ();

   rgb_3x3_kernel_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rkf_filter_checker filter_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned used_width(int unsigned v);
      if (v < 3) return 3;
      if (v > 2048) return 2048;
      return v;
   endfunction

   // random channel, leaning on the extremes now and then
   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pix_type random_pixel();
      return {random_channel(), random_channel(), random_channel()};
   endfunction

   // one item on the request channel, returns at the edge that takes it
   task automatic send_item(logic op, pix_type pix);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.red_in   <= pix.red;
      req_ch.green_in <= pix.green;
      req_ch.blue_in  <= pix.blue;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // pad the open row, then the two flush rows; noisy puts pixel items
   // among the flush items after the first
   task automatic finish_frame(int unsigned w, int unsigned sent, bit noisy);
      int unsigned col;
      int unsigned count;
      logic        op;
      col   = sent % w;
      count = (col == 0 ? 0 : w - col) + 2 * w;
      for (int unsigned k = 0; k < count; k++) begin
         op = (k == 0 || !noisy || $urandom_range(0, 3) != 0) ? OP_FLUSH : OP_PIXEL;
         send_item(op, random_pixel());
      end
   endtask

   task automatic send_pixels(int unsigned n);
      for (int unsigned k = 0; k < n; k++)
         send_item(OP_PIXEL, random_pixel());
   endtask

   task automatic run_frame(int unsigned w, int unsigned n_pix, bit noisy);
      send_pixels(n_pix);
      finish_frame(w, n_pix, noisy);
   endtask

   // result side: random stall per item, or a long hold when asked
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != holds_requested) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = receiver_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // stimulus
   initial begin
      pix_type     corner_pixels [0:8];
      int unsigned w;
      int unsigned n_pix;

      corner_pixels = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                        24'h000000, 24'hFFFFFF, 24'h000000,
                        24'hFF0000, 24'h00FF00, 24'h0000FF};

      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_FILTER_MODE;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_PIXEL;
      req_ch.red_in   <= '0;
      req_ch.green_in <= '0;
      req_ch.blue_in  <= '0;
      sender_gaps     = 1'b0;
      receiver_gaps   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge detect on a full 3x3 frame of extreme pixels
      write_reg(CSR_FILTER_MODE, MODE_EDGE);
      write_reg(CSR_IMAGE_WIDTH, 3);
      foreach (corner_pixels[k])
         send_item(OP_PIXEL, corner_pixels[k]);
      finish_frame(3, 9, 1'b0);
      drain();

      // sharpen, flush in mid-row, pixels among the flush items
      write_reg(CSR_FILTER_MODE, MODE_SHARPEN);
      write_reg(CSR_IMAGE_WIDTH, 4);
      send_item(OP_PIXEL, 24'hFFFFFF);
      send_item(OP_PIXEL, 24'h000000);
      send_item(OP_PIXEL, 24'hFFFFFF);
      send_item(OP_PIXEL, 24'h808080);
      send_item(OP_PIXEL, 24'hFFFFFF);
      finish_frame(4, 5, 1'b1);
      drain();

      // empty frame at a width below the minimum
      write_reg(CSR_IMAGE_WIDTH, 0);
      finish_frame(3, 0, 1'b0);
      drain();

      // random frames, mostly well formed, small widths
      for (int f = 0; f < 8; f++) begin
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1) == 0)
            write_reg(CSR_FILTER_MODE, $urandom_range(0, 3));
         if ($urandom_range(0, 5) == 0) w = $urandom_range(1, 2);
         else w = $urandom_range(3, 12);
         write_reg(CSR_IMAGE_WIDTH, w);
         w     = used_width(w);
         n_pix = $urandom_range(0, 3) * w;
         if ($urandom_range(0, 1) == 0) n_pix += $urandom_range(0, w - 1);
         run_frame(w, n_pix, $urandom_range(0, 2) == 0);
         drain();
      end

      // mode change in mid-frame, once the block has gone idle
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      write_reg(CSR_FILTER_MODE, MODE_BOX);
      write_reg(CSR_IMAGE_WIDTH, 6);
      send_pixels(14);
      drain();
      write_reg(CSR_FILTER_MODE, MODE_GAUSS);
      finish_frame(6, 14, 1'b0);
      drain();

      // a width write abandons a half-done frame
      send_pixels(9);
      drain();
      write_reg(CSR_IMAGE_WIDTH, 5);
      run_frame(5, 12, 1'b1);
      drain();

      // result side held off while the sender keeps offering
      sender_gaps = 1'b0;
      write_reg(CSR_FILTER_MODE, MODE_EDGE);
      write_reg(CSR_IMAGE_WIDTH, 8);
      holds_requested++;
      run_frame(8, 32, 1'b0);
      drain();

      // widest width: saturates at the line length; a short partial row,
      // left open and abandoned by the next width write
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b1;
      write_reg(CSR_FILTER_MODE, MODE_GAUSS);
      write_reg(CSR_IMAGE_WIDTH, 4095);
      send_pixels(5);
      drain();

      // a last small frame at the minimum width, sharpen
      sender_gaps = 1'b1;
      write_reg(CSR_FILTER_MODE, MODE_SHARPEN);
      write_reg(CSR_IMAGE_WIDTH, 3);
      run_frame(3, 9, 1'b1);
      drain();

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
